@@ rtl/core/u8cp_pkg.sv @@
package u8cp_pkg;

   // Replacement character for anything that cannot be shown in Windows-1252.
   localparam logic [7:0] QMARK = 8'h3F;

   // Number of follower bytes still due in an open sequence.
   localparam logic [1:0] FOLLOW_NONE = 2'd0;
   localparam logic [1:0] FOLLOW_ONE  = 2'd1;
   localparam logic [1:0] FOLLOW_TWO  = 2'd2;

   // Code points that Windows-1252 places at bytes 0x80 to 0x9F; zero marks a hole.
   localparam logic [15:0] HIGH_TABLE [32] = '{
      16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
      16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
      16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
      16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
   };

   // Results that one input word produces: none, one, or two.
   typedef struct packed {
      logic [1:0] count;
      logic [7:0] char0;
      logic [7:0] char1;
   } push_type;

   function automatic logic [7:0] map_point(input logic [15:0] cp);
      logic [7:0] res;
      res = QMARK;
      if (cp < 16'h0080 || (cp >= 16'h00A0 && cp <= 16'h00FF)) begin
         res = cp[7:0];
      end else begin
         for (int k = 0; k < 32; k++) begin
            if (HIGH_TABLE[k] != 16'h0000 && HIGH_TABLE[k] == cp) begin
               res = {3'b100, 5'(k)};
            end
         end
      end
      return res;
   endfunction

endpackage

@@ rtl/core/u8cp_if.sv @@
interface u8cp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       stream_end;

   modport source (output valid, output data_byte, output stream_end, input ready);
   modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface u8cp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       run_end;

   modport source (output valid, output char_byte, output run_end, input ready);
   modport sink   (input valid, input char_byte, input run_end, output ready);
endinterface

@@ rtl/core/utf8_to_cp1252_transcoder_unit.sv @@
// Channel   Dir   Fields                  Meaning
// req       in    data_byte, stream_end   UTF-8 input stream, one byte per word
// rsp       out   char_byte, run_end      Windows-1252 bytes, run_end on last of a word
//
// A word waits in the input register until the queue has room, is decoded, and its
// results enter a four-entry result queue. One word is accepted per cycle while the
// queue has room; a truncated three-byte sequence writes two results.
// Input stalls only while the result queue holds more than two results.
// Synchronous reset closes any open sequence and empties the result queue.
module utf8_to_cp1252_transcoder_unit (
   input  logic       clock,
   input  logic       reset,
   u8cp_req_if.sink   req,
   u8cp_rsp_if.source rsp
);

   logic               in_valid_ff;
   logic               in_valid_in;
   logic [7:0]         in_data_ff;
   logic               in_end_ff;
   logic               room;
   logic               fire;
   logic               take;
   u8cp_pkg::push_type push;

   assign fire      = in_valid_ff && room;
   assign req.ready = !in_valid_ff || fire;
   assign take      = req.valid && req.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req.data_byte;
         in_end_ff  <= req.stream_end;
      end
   end

   u8cp_decoder u_decoder (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .data_byte  (in_data_ff),
      .stream_end (in_end_ff),
      .push       (push)
   );

   u8cp_result_fifo u_result_fifo (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .push  (push),
      .room  (room),
      .rsp   (rsp)
   );

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      fire |-> push.count != 2'd3)
      else $error("decoder produced more than two results for one word");

   a_held_word: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> in_valid_ff)
      else $error("stalled input word was dropped");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid)
      else $error("result queue not empty after reset");

endmodule

@@ rtl/core/u8cp_decoder.sv @@
module u8cp_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic [7:0]         data_byte,
   input  logic               stream_end,
   output u8cp_pkg::push_type push
);

   logic [1:0] follow_ff;
   logic [1:0] follow_in;
   logic [9:0] point_ff;
   logic [9:0] point_in;

   logic       fresh_emit;
   logic [7:0] fresh_char;
   logic [1:0] fresh_follow;
   logic [9:0] fresh_point;

   // Handling of a byte that arrives with no sequence open.
   always_comb begin
      fresh_emit   = 1'b1;
      fresh_char   = u8cp_pkg::QMARK;
      fresh_follow = u8cp_pkg::FOLLOW_NONE;
      fresh_point  = point_ff;
      if (!data_byte[7]) begin
         fresh_char = data_byte;
      end else if (data_byte[7:5] == 3'b110) begin
         if (!stream_end) begin
            fresh_emit   = 1'b0;
            fresh_follow = u8cp_pkg::FOLLOW_ONE;
            fresh_point  = {5'b0, data_byte[4:0]};
         end
      end else if (data_byte[7:4] == 4'b1110) begin
         if (!stream_end) begin
            fresh_emit   = 1'b0;
            fresh_follow = u8cp_pkg::FOLLOW_TWO;
            fresh_point  = {6'b0, data_byte[3:0]};
         end
      end
   end

   always_comb begin
      push       = '0;
      push.char1 = fresh_char;
      follow_in  = follow_ff;
      point_in   = point_ff;
      case (follow_ff)
         u8cp_pkg::FOLLOW_TWO: begin
            if (stream_end) begin
               // The cut-off lead gives '?', then the byte is taken on its own.
               push.count = 2'd2;
               push.char0 = u8cp_pkg::QMARK;
               follow_in  = u8cp_pkg::FOLLOW_NONE;
            end else begin
               point_in  = {point_ff[3:0], data_byte[5:0]};
               follow_in = u8cp_pkg::FOLLOW_ONE;
            end
         end
         u8cp_pkg::FOLLOW_ONE: begin
            push.count = 2'd1;
            push.char0 = u8cp_pkg::map_point({point_ff, data_byte[5:0]});
            follow_in  = u8cp_pkg::FOLLOW_NONE;
         end
         default: begin
            push.count = {1'b0, fresh_emit};
            push.char0 = fresh_char;
            follow_in  = fresh_follow;
            point_in   = fresh_point;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         follow_ff <= u8cp_pkg::FOLLOW_NONE;
      end else if (fire) begin
         follow_ff <= follow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         point_ff <= point_in;
      end
   end

endmodule

@@ rtl/core/u8cp_result_fifo.sv @@
module u8cp_result_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  u8cp_pkg::push_type push,
   output logic               room,
   u8cp_rsp_if.source         rsp
);

   localparam int Depth = 4;
   localparam int PtrW  = $clog2(Depth);

   logic [8:0]      mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [PtrW-1:0] rd_ptr_in;
   logic [PtrW:0]   count_ff;
   logic [PtrW:0]   count_in;
   logic [1:0]      n_push;
   logic            pop;

   assign n_push = fire ? push.count : 2'd0;
   assign pop    = rsp.valid && rsp.ready;

   // A word may produce two results, so keep space for two.
   assign room = count_ff <= (PtrW + 1)'(Depth - 2);

   assign rsp.valid     = count_ff != '0;
   assign rsp.char_byte = mem_ff[rd_ptr_ff][8:1];
   assign rsp.run_end   = mem_ff[rd_ptr_ff][0];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrW'(n_push);
      rd_ptr_in = rd_ptr_ff + PtrW'(pop);
      count_in  = count_ff + (PtrW + 1)'(n_push) - (PtrW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         mem_ff[wr_ptr_ff] <= {push.char0, push.count == 2'd1};
      end
      if (n_push == 2'd2) begin
         mem_ff[wr_ptr_ff + PtrW'(1)] <= {push.char1, 1'b1};
      end
   end

endmodule
